// File: design/assert_macros.svh
// Assertion helpers included by the rate limiter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define SWRL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the trigger.
`define SWRL_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: design/swrl_pkg.sv
package swrl_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF  = 32;

    localparam int ARRIVAL_W = 32;
    localparam int MAX_W     = 7;
    localparam int WINDOW_W  = 16;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;

    localparam logic [MAX_W-1:0]    MAX_IN_WINDOW_RST = 7'd5;
    localparam logic [WINDOW_W-1:0] WINDOW_LENGTH_RST = 16'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FINISH
    } swrl_state_t;

endpackage

// File: design/swrl_stamp_ram.sv
module swrl_stamp_ram #(
    parameter int DEPTH  = swrl_pkg::RING_DEPTH_DEF,
    parameter int DATA_W = swrl_pkg::TIME_BITS_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/swrl_age_unit.sv
module swrl_age_unit #(
    parameter int TIME_BITS = swrl_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0]          now,
    input  logic [TIME_BITS-1:0]          stamp,
    input  logic [swrl_pkg::WINDOW_W-1:0] window_length,
    output logic                          expired
);

    localparam int AGE_W = (TIME_BITS > swrl_pkg::WINDOW_W) ? TIME_BITS : swrl_pkg::WINDOW_W;

    logic [TIME_BITS-1:0] age;

    // Age wraps with the time counter.
    assign age     = now - stamp;
    assign expired = AGE_W'(age) >= AGE_W'(window_length);

endmodule

// File: design/sliding_window_rate_limiter_unit.sv
// Sliding window log rate limiter.
// Input channel (s_valid/s_ready/s_arrival_time): one request per transfer,
// carrying its own arrival time in ms. Output channel (m_valid/m_ready,
// m_allowed, m_in_window_count): one result per request, in order.
// Configuration: cfg_wr_en with cfg_index/cfg_wdata writes max_in_window
// (index 0) or window_length (index 1); other indexes are ignored. Write only
// while the block is idle.
// Sequencing: a transferred request goes to the check state, which drops the
// expired stamps from the oldest end, then to the finish state, which loads
// its result into the output register. The sequencer walks the single read
// port of the stamp memory one stamp a cycle. Each stamp is dropped once, so
// on average a request drops at most one stamp.
// s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous) empties the ring and restores the register
// defaults (limit 5, window 1000 ms); the memory needs no clearing pass.
// A stalled receiver holds the result in the output register; the next request
// is still taken and worked through, and waits in its last step for the slot.
module sliding_window_rate_limiter_unit #(
    parameter int RING_DEPTH = swrl_pkg::RING_DEPTH_DEF,
    parameter int TIME_BITS  = swrl_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [swrl_pkg::ARRIVAL_W-1:0]  s_arrival_time,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_allowed,
    output logic [swrl_pkg::COUNT_W-1:0]    m_in_window_count,
    input  logic                            cfg_wr_en,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    `include "assert_macros.svh"

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int LIM_W = (CNT_W > swrl_pkg::MAX_W) ? CNT_W : swrl_pkg::MAX_W;
    localparam int SUM_W = CNT_W + 1;

    // Configuration registers.
    logic [swrl_pkg::MAX_W-1:0]    max_reg;
    logic [swrl_pkg::WINDOW_W-1:0] window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg    <= swrl_pkg::MAX_IN_WINDOW_RST;
            window_reg <= swrl_pkg::WINDOW_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                swrl_pkg::CFG_MAX_IN_WINDOW: max_reg    <= cfg_wdata[swrl_pkg::MAX_W-1:0];
                swrl_pkg::CFG_WINDOW_LENGTH: window_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer and ring state.
    swrl_pkg::swrl_state_t state_reg, state_next;
    logic [IDX_W-1:0]      oldest_reg, oldest_next;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic [TIME_BITS-1:0]  now_reg;

    logic                  m_valid_reg, m_valid_next;
    logic                  allowed_reg;
    logic [swrl_pkg::COUNT_W-1:0] count_reg;

    logic                  accept;
    logic                  pop;
    logic                  out_free;
    logic                  load;
    logic                  expired;
    logic                  have_room;
    logic [IDX_W-1:0]      oldest_inc;
    logic [IDX_W-1:0]      slot;
    logic [SUM_W-1:0]      slot_sum;
    logic [LIM_W-1:0]      limit;
    logic [CNT_W-1:0]      held_inc;
    logic [LIM_W-1:0]      count_ext;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [TIME_BITS-1:0]  rd_stamp;

    // Saturate the limit at the ring depth.
    assign limit = (LIM_W'(max_reg) > LIM_W'(RING_DEPTH)) ? LIM_W'(RING_DEPTH)
                                                          : LIM_W'(max_reg);
    assign have_room = LIM_W'(held_reg) < limit;
    assign held_inc  = held_reg + 1'b1;

    assign oldest_inc = (oldest_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;

    // Newest free slot: oldest + held stays below twice the depth.
    assign slot_sum = SUM_W'(oldest_reg) + SUM_W'(held_reg);
    assign slot = (slot_sum >= SUM_W'(RING_DEPTH)) ? IDX_W'(slot_sum - SUM_W'(RING_DEPTH))
                                                   : IDX_W'(slot_sum);

    // Controls of the current step.
    always_comb begin
        accept   = 1'b0;
        pop      = 1'b0;
        load     = 1'b0;
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = oldest_reg;
        out_free = !m_valid_reg || m_ready;
        case (state_reg)
            swrl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                accept  = s_valid;
                // Fetch the oldest stamp as the request comes in.
                rd_en   = s_valid;
            end
            swrl_pkg::ST_CHECK: begin
                pop     = (held_reg != '0) && expired;
                // Fetch the next oldest stamp while dropping this one.
                rd_en   = pop;
                rd_addr = oldest_inc;
            end
            swrl_pkg::ST_FINISH: begin
                load = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swrl_pkg::ST_IDLE:   if (accept) state_next = swrl_pkg::ST_CHECK;
            swrl_pkg::ST_CHECK:  if (!pop) state_next = swrl_pkg::ST_FINISH;
            swrl_pkg::ST_FINISH: if (load) state_next = swrl_pkg::ST_IDLE;
            default:             state_next = swrl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        oldest_next = oldest_reg;
        held_next   = held_reg;
        if (pop) begin
            oldest_next = oldest_inc;
            held_next   = held_reg - 1'b1;
        end else if (load && have_room) begin
            held_next = held_inc;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign count_ext = LIM_W'(held_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swrl_pkg::ST_IDLE;
            oldest_reg  <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: hold the request time and the pending result.
    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg <= TIME_BITS'(s_arrival_time);
        end
        if (load) begin
            allowed_reg <= have_room;
            count_reg   <= count_ext[swrl_pkg::COUNT_W-1:0];
        end
    end

    swrl_stamp_ram #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (TIME_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (load && have_room),
        .wr_addr (slot),
        .wr_data (now_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_stamp)
    );

    swrl_age_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_age (
        .now           (now_reg),
        .stamp         (rd_stamp),
        .window_length (window_reg),
        .expired       (expired)
    );

    assign m_valid           = m_valid_reg;
    assign m_allowed         = allowed_reg;
    assign m_in_window_count = count_reg;

    // Ring occupancy never goes past the depth.
    `SWRL_ASSERT(a_held_bound, held_reg <= CNT_W'(RING_DEPTH), "ring count above depth")
    // A drop removes exactly one stamp.
    `SWRL_ASSERT_NEXT(a_pop_dec, pop, held_reg == $past(held_reg) - 1'b1, "drop count slip")
    // A result is loaded only when the output slot is free.
    `SWRL_ASSERT(a_load_free, !load || !m_valid_reg || m_ready, "result overwrote pending")
    // Every loaded result reports the count it leaves behind (checked while the ring count fits seven bits).
    `SWRL_ASSERT_NEXT(a_count_match, load,
                      LIM_W'(m_in_window_count) == LIM_W'(held_reg) || CNT_W > 7,
                      "reported count mismatch")

endmodule

// File: bench/swrl_verdict_checker.sv
module swrl_verdict_checker
    import swrl_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [ARRIVAL_W-1:0]  s_arrival_time,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_allowed,
    input  logic [COUNT_W-1:0]    m_in_window_count,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    verdicts_owed
);

    typedef struct packed {
        logic               allowed;
        logic [COUNT_W-1:0] held;
    } verdict_t;

    logic [ARRIVAL_W-1:0] stamps [DEPTH];
    int unsigned          head_slot;
    int unsigned          held_stamps;
    logic [MAX_W-1:0]     limit_reg;
    logic [WINDOW_W-1:0]  window_reg;
    verdict_t             owed_verdicts [$];
    int                   fails = 0;

    // Drop expired stamps from the oldest end, then admit if room is left.
    task automatic judge_request(input logic [ARRIVAL_W-1:0] now_ms, output verdict_t v);
        int unsigned          cap;
        logic [ARRIVAL_W-1:0] age;
        cap = (limit_reg > DEPTH) ? DEPTH : limit_reg;
        while (held_stamps > 0) begin
            age = now_ms - stamps[head_slot];
            if (age < {{(ARRIVAL_W-WINDOW_W){1'b0}}, window_reg})
                break;
            head_slot = (head_slot + 1) % DEPTH;
            held_stamps--;
        end
        v.allowed = 1'b0;
        if (held_stamps < cap) begin
            stamps[(head_slot + held_stamps) % DEPTH] = now_ms;
            held_stamps++;
            v.allowed = 1'b1;
        end
        v.held = COUNT_W'(held_stamps);
    endtask

    always @(posedge aclk) begin : watch
        verdict_t want;
        if (!aresetn) begin
            head_slot   = 0;
            held_stamps = 0;
            limit_reg   = MAX_IN_WINDOW_RST;
            window_reg  = WINDOW_LENGTH_RST;
            owed_verdicts.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAX_IN_WINDOW: limit_reg = cfg_wdata[MAX_W-1:0];
                    CFG_WINDOW_LENGTH: window_reg = cfg_wdata[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (owed_verdicts.size() == 0) begin
                    $error("result with no request pending: allowed=%0d in_window_count=%0d",
                           m_allowed, m_in_window_count);
                    fails++;
                end else begin
                    want = owed_verdicts.pop_front();
                    if (m_allowed !== want.allowed) begin
                        $error("allowed: expected %0d, actual %0d", want.allowed, m_allowed);
                        fails++;
                    end
                    if (m_in_window_count !== want.held) begin
                        $error("in_window_count: expected %0d, actual %0d",
                               want.held, m_in_window_count);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                judge_request(s_arrival_time, want);
                owed_verdicts.push_back(want);
            end
        end
        fail_count    <= fails;
        verdicts_owed <= owed_verdicts.size();
    end

endmodule

// File: bench/sliding_window_rate_limiter_unit_test.sv
// Top of the rate limiter bench: clock, reset, request stimulus, receiver
// back-pressure, register programming and the verdict. All prediction and
// comparison lives in the checker instantiated beside the block.
module sliding_window_rate_limiter_unit_test;
    import swrl_pkg::*;

    // Watchdog cycle limit, set far above what a correct run needs.
    localparam int RUN_LIMIT = 400000;
    // A request can drop every held stamp before its result, so the wait grows with the ring depth.
    localparam int SETTLE_CYCLES = RING_DEPTH_DEF + 8;

    // Register indexes that decode to nothing; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ARRIVAL_W-1:0]  s_arrival_time = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_allowed;
    logic [COUNT_W-1:0]    m_in_window_count;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int verdicts_owed;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    sliding_window_rate_limiter_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_arrival_time    (s_arrival_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_allowed         (m_allowed),
        .m_in_window_count (m_in_window_count),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    swrl_verdict_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_arrival_time    (s_arrival_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_allowed         (m_allowed),
        .m_in_window_count (m_in_window_count),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .fail_count        (fail_count),
        .verdicts_owed     (verdicts_owed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: drop ready at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    always @(posedge aclk) begin
        if (cycle_count >= RUN_LIMIT) begin
            $display("sliding_window_rate_limiter_unit_test failed");
            $finish;
        end
        cycle_count <= cycle_count + 1;
    end

    // Offer one request and hold it until the transfer. Valid is only lowered
    // for a random gap, so back-to-back requests keep it high.
    task automatic send_request(input logic [ARRIVAL_W-1:0] stamp_ms);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_valid        <= 1'b1;
        s_arrival_time <= stamp_ms;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every result is back and the block is idle.
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both registers, each followed by a junk write to an unmapped index.
    // Keep the write enable high across the burst and drop it once at the end.
    task automatic program_limits(input logic [CFG_DATA_W-1:0] max_word,
                                  input logic [CFG_DATA_W-1:0] win_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAX_IN_WINDOW;
        cfg_wdata <= max_word;
        @(posedge aclk);
        cfg_index <= CFG_UNMAPPED_LO;
        cfg_wdata <= CFG_DATA_W'($urandom());
        @(posedge aclk);
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_wdata <= win_word;
        @(posedge aclk);
        cfg_index <= CFG_UNMAPPED_HI;
        cfg_wdata <= CFG_DATA_W'($urandom());
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Pick the next arrival time. Most steps are bursts at the same time or
    // small advances sized so the window fills to its limit; some jump past
    // the window, and a few go backwards or land anywhere.
    function automatic logic [ARRIVAL_W-1:0] next_stamp(input logic [ARRIVAL_W-1:0] now_ms,
                                                        input int unsigned win,
                                                        input int unsigned cap);
        int unsigned pick;
        int unsigned spread;
        pick   = $urandom_range(99);
        spread = (cap == 0) ? win : (2 * win) / cap;
        if (pick < 2)
            return $urandom();
        if (pick < 4)
            return now_ms - $urandom_range(win + 1, 1);
        if (pick < 22)
            return now_ms;
        if (pick < 88)
            return now_ms + $urandom_range(spread + 1, 0);
        return now_ms + win + $urandom_range(win, 0);
    endfunction

    // One register setting, then a run of requests against it.
    task automatic run_phase(input int items,
                             input logic [CFG_DATA_W-1:0] max_word,
                             input logic [CFG_DATA_W-1:0] win_word,
                             input logic [ARRIVAL_W-1:0] start_ms);
        int unsigned          cap;
        int unsigned          win;
        logic [ARRIVAL_W-1:0] now_ms;
        quiesce();
        program_limits(max_word, win_word);
        cap    = (max_word[MAX_W-1:0] > RING_DEPTH_DEF) ? RING_DEPTH_DEF
                                                        : max_word[MAX_W-1:0];
        win    = win_word;
        now_ms = start_ms;
        repeat (items) begin
            now_ms = next_stamp(now_ms, win, cap);
            send_request(now_ms);
            // Now and then hold off until every result has come back.
            if ($urandom_range(59) == 0)
                quiesce();
        end
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Default limit 5, window 1000: fill the window, then reject.
        repeat (6) send_request(32'd0);
        send_request(32'd999);            // still inside the window: reject
        send_request(32'd1000);           // age equals the window: all expire
        send_request(32'hFFFF_FFFF);      // top of the counter
        send_request(32'd5);              // counter wraps, small age
        send_request(32'h8000_0000);
        send_request(32'h0000_0010);      // time goes backwards: wrapped age expires all

        // Limit zero (upper junk bits masked off): reject, expiry still runs.
        quiesce();
        program_limits(16'hFF80, 16'd1000);
        send_request(32'd20);
        send_request(32'd21);
        send_request(32'd2000);

        // Limit above the ring depth with a zero window: every stamp expires.
        quiesce();
        program_limits(16'h007F, 16'h0000);
        repeat (3) send_request(32'd3000);

        // Limit one with the longest window: edge of the window.
        quiesce();
        program_limits(16'd1, 16'hFFFF);
        send_request(32'd5000);
        send_request(32'd5000);
        send_request(32'd5000 + 32'd65534);
        send_request(32'd5000 + 32'd65535);

        // Random part: slow receiver first, then slow sender, then full rate.
        sender_idle_pct   = 13;
        receiver_idle_pct = 64;
        run_phase(195, 16'd5, 16'd1000, $urandom());
        run_phase(195, 16'd64, 16'hFFFF, 32'hFFFF_0000);
        run_phase(195, 16'd127, 16'd40000, $urandom());
        run_phase(195, 16'hFF80, 16'd300, $urandom());

        sender_idle_pct   = 64;
        receiver_idle_pct = 13;
        run_phase(195, 16'd1, 16'd1, $urandom());
        run_phase(195, 16'd3, 16'd0, $urandom());
        run_phase(195, 16'($urandom_range(64, 1)), 16'($urandom_range(65535, 1)), $urandom());

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_phase(195, 16'($urandom()), 16'($urandom()), $urandom());
        run_phase(195, 16'($urandom()), 16'($urandom()), $urandom());
        run_phase(195, 16'($urandom()), 16'($urandom()), $urandom());

        quiesce();
        if (fail_count == 0)
            $display("sliding_window_rate_limiter_unit_test passed");
        else
            $display("sliding_window_rate_limiter_unit_test failed");
        $finish;
    end

endmodule
